>>> design/cbts_pkg.sv
package cbts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int HANDLE_BITS = 16;

    localparam int TIME_BITS   = 32;
    localparam int HPORT_BITS  = 16;
    localparam int SIDX_BITS   = $clog2(STACK_DEPTH);
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
    // stored handle width never exceeds the port width
    localparam int SH_BITS     = (HANDLE_BITS < HPORT_BITS) ? HANDLE_BITS : HPORT_BITS;

    localparam int BIDX_BITS   = 12;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BUCKET_INDEX = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUCKET_WIDTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YEAR_LENGTH  = 2'd2;

    localparam int IN_BYTES_BITS  = 56;
    localparam int OUT_BYTES_BITS = 56;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_GET    = 2'd1,
        CMD_PEEK   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EARLY = 2'd1,
        STS_FULL  = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GET,
        ST_REORG_RD,
        ST_REORG_WR
    } t_state;

    typedef struct packed {
        logic [SH_BITS-1:0]   handle;
        logic [TIME_BITS-1:0] evt_time;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // input word, lowest field last
    typedef struct packed {
        logic [IN_BYTES_BITS-TIME_BITS-HPORT_BITS-3:0] pad;
        logic [HPORT_BITS-1:0] item_handle;
        logic [TIME_BITS-1:0]  event_time;
        logic [1:0]            cmd;
    } t_in_word;

    // output word, lowest field last
    typedef struct packed {
        logic [OUT_BYTES_BITS-TIME_BITS-HPORT_BITS-5:0] pad;
        logic                  advanced;
        logic [HPORT_BITS-1:0] out_handle;
        logic [TIME_BITS-1:0]  item_time;
        logic                  item_valid;
        t_status               status;
    } t_out_word;

endpackage

>>> design/cbts_ram.sv
module cbts_ram
    import cbts_pkg::*;
#(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [(1 << ADDR_BITS)];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/calendar_bucket_two_stack_core.sv
// One bucket of a calendar event queue. Words on the slave side are commands:
// insert (time, handle), get (pop the current-year stack) or peek (read its
// top). Every word gives exactly one result word. A get or peek that finds
// an item first reads the current stack, which sits in a RAM with a
// registered read port. A get or peek on an empty current stack reports
// "empty" with advanced set at once, moves the window up by year_length,
// and then walks the future stack out of its RAM from the top down,
// through ST_REORG_RD and then ST_REORG_WR for each entry, with
// s_axis_tready low. The future stack lives in two banks of one RAM; the
// walk reads one bank and rebuilds the survivors in the other, then swaps.
// One result register sits on the master side; a new word is taken while the
// previous result is being drained. Config writes are only legal while idle;
// writing bucket_index or bucket_width reloads the window bounds.
module calendar_bucket_two_stack_core
    import cbts_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // command words
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: cmd[1:0], event_time[33:2], item_handle[49:34], zero pad
    input  logic [IN_BYTES_BITS-1:0]  s_axis_tdata,
    // result words
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata: status[1:0], item_valid[2], item_time[34:3], out_handle[50:35],
    //        advanced[51], zero pad
    output logic [OUT_BYTES_BITS-1:0] m_axis_tdata
);

    // ---- registers ----
    t_state                 r_state, n_state;
    logic [BIDX_BITS-1:0]   r_bidx, n_bidx;
    logic [TIME_BITS-1:0]   r_bwidth, n_bwidth;
    logic [TIME_BITS-1:0]   r_ylen, n_ylen;
    logic [TIME_BITS-1:0]   r_start, n_start;
    logic [TIME_BITS-1:0]   r_end, n_end;
    logic [CNT_BITS-1:0]    r_cc, n_cc;       // current stack fill
    logic [CNT_BITS-1:0]    r_fc, n_fc;       // future stack fill
    logic                   r_fbank, n_fbank; // live future bank
    logic [SIDX_BITS-1:0]   r_ridx, n_ridx;   // future entry under walk
    logic [CNT_BITS-1:0]    r_nf, n_nf;       // survivors written so far
    logic                   r_ovalid;
    t_out_word              r_out, n_out;
    logic                   out_load;

    // ---- RAM ports ----
    logic                   cur_we, cur_re;
    logic [SIDX_BITS-1:0]   cur_waddr, cur_raddr;
    t_entry                 cur_wdata;
    logic [ENTRY_BITS-1:0]  cur_rdata_raw;
    t_entry                 cur_rdata;
    logic                   fut_we, fut_re;
    logic [SIDX_BITS:0]     fut_waddr, fut_raddr;
    t_entry                 fut_wdata;
    logic [ENTRY_BITS-1:0]  fut_rdata_raw;
    t_entry                 fut_rdata;

    t_in_word               in_w;
    logic                   in_acc;
    t_entry                 in_ent;

    // window reload product
    logic [BIDX_BITS-1:0]            win_idx;
    logic [TIME_BITS-1:0]            win_width;
    logic [BIDX_BITS+TIME_BITS-1:0]  win_prod;
    logic [TIME_BITS-1:0]            win_start;

    cbts_ram #(
        .ADDR_BITS (SIDX_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_re    (cur_re),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata_raw)
    );

    cbts_ram #(
        .ADDR_BITS (SIDX_BITS + 1),
        .DATA_BITS (ENTRY_BITS)
    ) u_fut_ram (
        .i_clk   (i_clk),
        .i_we    (fut_we),
        .i_waddr (fut_waddr),
        .i_wdata (fut_wdata),
        .i_re    (fut_re),
        .i_raddr (fut_raddr),
        .o_rdata (fut_rdata_raw)
    );

    assign cur_rdata = t_entry'(cur_rdata_raw);
    assign fut_rdata = t_entry'(fut_rdata_raw);

    assign in_w            = t_in_word'(s_axis_tdata);
    assign in_ent.evt_time = in_w.event_time;
    assign in_ent.handle   = in_w.item_handle[SH_BITS-1:0];
    // only idle takes a word, and only when the result slot is free or draining
    assign s_axis_tready   = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_acc          = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // start = index * width (low 32 bits), end = start + width
    always_comb begin
        win_idx   = r_bidx;
        win_width = r_bwidth;
        if (i_cfg_idx == CFG_BUCKET_INDEX) begin
            win_idx = i_cfg_data[BIDX_BITS-1:0];
        end
        if (i_cfg_idx == CFG_BUCKET_WIDTH) begin
            win_width = i_cfg_data[TIME_BITS-1:0];
        end
        win_prod  = (BIDX_BITS+TIME_BITS)'(win_idx) * (BIDX_BITS+TIME_BITS)'(win_width);
        win_start = win_prod[TIME_BITS-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_bidx   = r_bidx;
        n_bwidth = r_bwidth;
        n_ylen   = r_ylen;
        n_start  = r_start;
        n_end    = r_end;
        n_cc     = r_cc;
        n_fc     = r_fc;
        n_fbank  = r_fbank;
        n_ridx   = r_ridx;
        n_nf     = r_nf;
        n_out    = '0;
        out_load = 1'b0;

        cur_we    = 1'b0;
        cur_waddr = r_cc[SIDX_BITS-1:0];
        cur_wdata = in_ent;
        cur_re    = 1'b0;
        cur_raddr = SIDX_BITS'(r_cc - CNT_BITS'(1));
        fut_we    = 1'b0;
        fut_waddr = {r_fbank, r_fc[SIDX_BITS-1:0]};
        fut_wdata = in_ent;
        fut_re    = 1'b0;
        fut_raddr = {r_fbank, r_ridx};

        // config writes must arrive only while idle; the block does not enforce it
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUCKET_INDEX: begin
                    n_bidx  = i_cfg_data[BIDX_BITS-1:0];
                    n_start = win_start;
                    n_end   = win_start + win_width;
                end
                CFG_BUCKET_WIDTH: begin
                    n_bwidth = i_cfg_data[TIME_BITS-1:0];
                    n_start  = win_start;
                    n_end    = win_start + win_width;
                end
                CFG_YEAR_LENGTH: n_ylen = i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_w.cmd)
                        CMD_INSERT: begin
                            out_load = 1'b1;
                            if (in_w.event_time < r_start) begin
                                n_out.status = STS_EARLY;
                            end else if (in_w.event_time < r_end) begin
                                if (r_cc == CNT_BITS'(STACK_DEPTH)) begin
                                    n_out.status = STS_FULL;
                                end else begin
                                    cur_we = 1'b1;
                                    n_cc   = r_cc + CNT_BITS'(1);
                                end
                            end else begin
                                if (r_fc == CNT_BITS'(STACK_DEPTH)) begin
                                    n_out.status = STS_FULL;
                                end else begin
                                    fut_we = 1'b1;
                                    n_fc   = r_fc + CNT_BITS'(1);
                                end
                            end
                        end
                        CMD_GET, CMD_PEEK: begin
                            if (r_cc == '0) begin
                                // empty: report now, then walk the future stack
                                out_load       = 1'b1;
                                n_out.status   = STS_EMPTY;
                                n_out.advanced = 1'b1;
                                n_start        = r_start + r_ylen;
                                n_end          = r_end + r_ylen;
                                if (r_fc != '0) begin
                                    n_ridx  = SIDX_BITS'(r_fc - CNT_BITS'(1));
                                    n_nf    = '0;
                                    n_state = ST_REORG_RD;
                                end
                            end else begin
                                cur_re  = 1'b1;
                                n_state = ST_GET;
                                if (in_w.cmd == CMD_GET) begin
                                    n_cc = r_cc - CNT_BITS'(1);
                                end
                            end
                        end
                        default: out_load = 1'b1;   // unused code: all-zero result
                    endcase
                end
            end
            ST_GET: begin
                out_load         = 1'b1;
                n_out.status     = STS_OK;
                n_out.item_valid = 1'b1;
                n_out.item_time  = cur_rdata.evt_time;
                n_out.out_handle = HPORT_BITS'(cur_rdata.handle);
                n_state          = ST_IDLE;
            end
            ST_REORG_RD: begin
                fut_re  = 1'b1;
                n_state = ST_REORG_WR;
            end
            ST_REORG_WR: begin
                // entry for r_ridx is on the read port; fetch the next one
                if (fut_rdata.evt_time < r_end) begin
                    if (r_cc < CNT_BITS'(STACK_DEPTH)) begin
                        cur_we    = 1'b1;
                        cur_wdata = fut_rdata;
                        n_cc      = r_cc + CNT_BITS'(1);
                    end
                end else if (r_nf < CNT_BITS'(STACK_DEPTH)) begin
                    fut_we    = 1'b1;
                    fut_waddr = {!r_fbank, r_nf[SIDX_BITS-1:0]};
                    fut_wdata = fut_rdata;
                    n_nf      = r_nf + CNT_BITS'(1);
                end
                if (r_ridx == '0) begin
                    n_fc    = n_nf;
                    n_fbank = !r_fbank;
                    n_state = ST_IDLE;
                end else begin
                    fut_re    = 1'b1;
                    fut_raddr = {r_fbank, r_ridx - SIDX_BITS'(1)};
                    n_ridx    = r_ridx - SIDX_BITS'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx   <= '0;
            r_bwidth <= TIME_BITS'(1);
            r_ylen   <= TIME_BITS'(1);
            r_start  <= '0;
            r_end    <= TIME_BITS'(1);
            r_cc     <= '0;
            r_fc     <= '0;
            r_fbank  <= 1'b0;
            r_ridx   <= '0;
            r_nf     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_bidx   <= n_bidx;
            r_bwidth <= n_bwidth;
            r_ylen   <= n_ylen;
            r_start  <= n_start;
            r_end    <= n_end;
            r_cc     <= n_cc;
            r_fc     <= n_fc;
            r_fbank  <= n_fbank;
            r_ridx   <= n_ridx;
            r_nf     <= n_nf;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // ---- checks ----
    a_cc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= CNT_BITS'(STACK_DEPTH))
        else $error("current fill beyond depth");

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= CNT_BITS'(STACK_DEPTH))
        else $error("future fill beyond depth");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("word taken while busy");

    a_empty_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_w.cmd == CMD_GET || in_w.cmd == CMD_PEEK) && r_cc == '0)
        |=> (m_axis_tvalid && r_out.advanced))
        else $error("empty get without advanced result");

    a_walk_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REORG_WR) |=> (r_cc >= $past(r_cc)))
        else $error("current stack shrank during walk");

endmodule

>>> tb/calendar_bucket_two_stack_core_tb.sv
// Bucket of a calendar event queue: stimulus, prediction and result checks.
module calendar_bucket_two_stack_core_tb
    import cbts_pkg::*;
();

    // cmd code 3 is not decoded by the bucket: it must give an all-zero word
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // a reorganize walks up to STACK_DEPTH future entries after its result
    localparam int QUIET_CYCLES = 2 * STACK_DEPTH + 8;

    typedef struct {
        t_status               status;
        logic                  item_valid;
        logic [TIME_BITS-1:0]  evt_time;
        logic [HPORT_BITS-1:0] handle;
        logic                  advanced;
    } t_bucket_result;

    // ---------------------------------------------------------------------
    // DUT ports; every input has a known value from time zero
    // ---------------------------------------------------------------------
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // tdata: cmd, event_time, item_handle, zero pad
    logic [IN_BYTES_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // tdata: status, item_valid, item_time, out_handle, advanced, zero pad
    logic [OUT_BYTES_BITS-1:0] m_axis_tdata;

    calendar_bucket_two_stack_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Bucket predictor: own copy of both stacks, window and registers
    // ---------------------------------------------------------------------
    t_entry               cur_stk [STACK_DEPTH];
    t_entry               fut_stk [STACK_DEPTH];
    int                   cur_n;
    int                   fut_n;
    logic [TIME_BITS-1:0] win_lo;
    logic [TIME_BITS-1:0] win_hi;
    logic [BIDX_BITS-1:0] cfg_bidx;
    logic [31:0]          cfg_width;
    logic [31:0]          cfg_year;

    t_bucket_result pending_results [$];   // predicted words, oldest first
    int             n_errors = 0;
    int             tx_idle_pct = 28;      // sender gap odds, percent
    int             rx_idle_pct = 28;      // receiver stall odds, percent
    int             rx_hold = 0;           // cycles of forced receiver stall

    // window bounds follow bucket_index and bucket_width, mod 2^32
    function automatic void load_window();
        win_lo = 32'(cfg_bidx) * cfg_width;
        win_hi = win_lo + cfg_width;
    endfunction

    // Year rollover: shift window, then pop every future entry. Those now
    // below the window end land on the current stack; the others form the
    // new future stack in popped (reversed) order.
    function automatic void roll_year();
        t_entry keep [STACK_DEPTH];
        t_entry e;
        int     nk;
        nk = 0;
        win_lo = win_lo + cfg_year;
        win_hi = win_hi + cfg_year;
        while (fut_n > 0) begin
            fut_n = fut_n - 1;
            e = fut_stk[fut_n];
            if (e.evt_time < win_hi) begin
                if (cur_n < STACK_DEPTH) begin
                    cur_stk[cur_n] = e;
                    cur_n++;
                end
            end else if (nk < STACK_DEPTH) begin
                keep[nk] = e;
                nk++;
            end
        end
        for (int k = 0; k < nk; k++) fut_stk[k] = keep[k];
        fut_n = nk;
    endfunction

    function automatic t_bucket_result predict_bucket(input logic [1:0] cmd,
                                                      input logic [TIME_BITS-1:0] t,
                                                      input logic [HPORT_BITS-1:0] h);
        t_bucket_result r;
        t_entry         e;
        r.status     = STS_OK;
        r.item_valid = 1'b0;
        r.evt_time   = '0;
        r.handle     = '0;
        r.advanced   = 1'b0;
        e.evt_time   = t;
        e.handle     = h[SH_BITS-1:0];
        case (cmd)
            CMD_INSERT: begin
                // too early wins over full
                if (t < win_lo) begin
                    r.status = STS_EARLY;
                end else if (t < win_hi) begin
                    if (cur_n >= STACK_DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        cur_stk[cur_n] = e;
                        cur_n++;
                    end
                end else begin
                    if (fut_n >= STACK_DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        fut_stk[fut_n] = e;
                        fut_n++;
                    end
                end
            end
            CMD_GET, CMD_PEEK: begin
                if (cur_n == 0) begin
                    r.status   = STS_EMPTY;
                    r.advanced = 1'b1;
                    roll_year();
                end else begin
                    r.item_valid = 1'b1;
                    r.evt_time   = cur_stk[cur_n-1].evt_time;
                    r.handle     = HPORT_BITS'(cur_stk[cur_n-1].handle);
                    if (cmd == CMD_GET) cur_n--;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    // One command word; inputs move on the falling edge, the handshake is
    // sampled on the rising edge. tvalid stays high into the next word.
    task automatic send_cmd(input logic [1:0] cmd, input logic [TIME_BITS-1:0] t,
                            input logic [HPORT_BITS-1:0] h);
        t_in_word w;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        w             = '0;
        w.cmd         = cmd;
        w.event_time  = t;
        w.item_handle = h;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_bucket(cmd, t, h));
    endtask

    // Sender pauses until every result is back, then lets a reorganize walk
    // run out before anything touches the config port.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_BUCKET_INDEX: begin
                cfg_bidx = val[BIDX_BITS-1:0];
                load_window();
            end
            CFG_BUCKET_WIDTH: begin
                cfg_width = val;
                load_window();
            end
            CFG_YEAR_LENGTH: cfg_year = val;
            default: ;
        endcase
    endtask

    task automatic set_bucket(input logic [31:0] bidx, input logic [31:0] width,
                              input logic [31:0] year);
        wait_quiet();
        write_reg(CFG_BUCKET_INDEX, bidx);
        write_reg(CFG_BUCKET_WIDTH, width);
        write_reg(CFG_YEAR_LENGTH, year);
    endtask

    // receiver: random stalls, or a counted hold-off when rx_hold is loaded
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word      ow;
        t_bucket_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            ow = m_axis_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", 32'(m_axis_tdata), '0);
            end else begin
                want = pending_results.pop_front();
                if (ow.status !== want.status)
                    report_mismatch("status", 32'(ow.status), 32'(want.status));
                if (ow.item_valid !== want.item_valid)
                    report_mismatch("item_valid", 32'(ow.item_valid), 32'(want.item_valid));
                if (ow.item_time !== want.evt_time)
                    report_mismatch("item_time", ow.item_time, want.evt_time);
                if (ow.out_handle !== want.handle)
                    report_mismatch("out_handle", 32'(ow.out_handle), 32'(want.handle));
                if (ow.advanced !== want.advanced)
                    report_mismatch("advanced", 32'(ow.advanced), 32'(want.advanced));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Random content
    // ---------------------------------------------------------------------
    // Times cluster around the window so that early rejects, current-year
    // pushes and future entries that migrate on a rollover all show up.
    function automatic logic [TIME_BITS-1:0] pick_time();
        logic [31:0] span;
        logic [31:0] reach;
        int          sel;
        sel   = $urandom_range(0, 99);
        span  = win_hi - win_lo;
        reach = (cfg_year > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF : cfg_year * 3;
        if (sel < 10 && win_lo != 0) return $urandom % win_lo;
        if (sel < 50 && span != 0) return win_lo + ($urandom % span);
        if (sel < 85) return win_hi + ($urandom % reach);
        case ($urandom_range(0, 3))
            0: return win_lo;
            1: return win_lo - 1;
            2: return win_hi;
            default: return $urandom;
        endcase
    endfunction

    // bursts of inserts and bursts of reads, with noise mixed in
    task automatic run_random_burst(input int n_words);
        int         sent;
        int         kind;
        int         len;
        int         sel;
        logic [1:0] cmd;
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                sel = $urandom_range(0, 99);
                if (kind < 5) begin
                    cmd = (sel < 5) ? CMD_GET : CMD_INSERT;
                end else if (kind < 9) begin
                    if (sel < 70)      cmd = CMD_GET;
                    else if (sel < 95) cmd = CMD_PEEK;
                    else               cmd = CMD_UNUSED;
                end else begin
                    cmd = 2'($urandom_range(0, 3));
                end
                send_cmd(cmd, pick_time(), 16'($urandom_range(0, 65535)));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // reset window is [0,1) with a year of 1
    task automatic test_reset_window();
        send_cmd(CMD_INSERT, 32'd0, 16'h1234);
        send_cmd(CMD_INSERT, 32'd1, 16'hEDCB);
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_GET, '0, '0);          // empty: rolls to [1,2), pulls t=1
        send_cmd(CMD_GET, '0, '0);
    endtask

    // window [200,300), year 300: boundaries, every command, empty peek
    task automatic test_directed_cases();
        set_bucket(32'd2, 32'd100, 32'd300);
        send_cmd(CMD_INSERT, 32'd199, 16'h5555);         // one below start
        send_cmd(CMD_INSERT, 32'd200, 16'hFFFF);         // start, inside
        send_cmd(CMD_INSERT, 32'd299, 16'h0000);         // last inside
        send_cmd(CMD_INSERT, 32'd300, 16'hAAAA);         // end is future
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hAAAA);   // top of time range
        send_cmd(CMD_INSERT, 32'd550, 16'h5555);         // migrates next year
        send_cmd(CMD_PEEK, '0, '0);
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_GET, '0, '0);                        // empty, rollover
        send_cmd(CMD_PEEK, '0, '0);
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);   // ignored command
        send_cmd(CMD_INSERT, 32'd0, 16'h0001);           // far too early
        send_cmd(CMD_PEEK, '0, '0);                       // empty peek rolls too
    endtask

    // Receiver held off while both stacks fill past their depth; the sender
    // keeps offering so the input stalls. Then drain and a full-depth walk.
    task automatic test_full_under_backpressure();
        set_bucket(32'd1, 32'd1000, 32'd1000);
        tx_idle_pct = 0;
        rx_hold     = 300;
        for (int k = 0; k <= STACK_DEPTH; k++)
            send_cmd(CMD_INSERT, 32'd1000 + k, 16'(k * 997));
        for (int k = 0; k <= STACK_DEPTH; k++)
            send_cmd(CMD_INSERT, 32'd2000 + k * 31, 16'(~(k * 331)));
        send_cmd(CMD_INSERT, 32'd5, 16'h00FF);          // early beats full
        tx_idle_pct = 28;
        for (int k = 0; k <= STACK_DEPTH; k++)
            send_cmd(CMD_GET, '0, '0);                   // last one rolls over
        send_cmd(CMD_PEEK, '0, '0);
        for (int k = 0; k < 8; k++)
            send_cmd(CMD_GET, '0, '0);
    endtask

    // random traffic under several windows, extremes and wrapped bounds
    task automatic test_random_settings();
        set_bucket(32'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_burst(150);
        set_bucket(32'd0, 32'd1, 32'd1);
        run_random_burst(150);
        // long stretch with no idling on either side
        set_bucket(32'd17, 32'h0100_0000, 32'h1000_0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_burst(150);
        tx_idle_pct = 28;
        rx_idle_pct = 28;
        // window end wraps below its start
        set_bucket(32'd4095, 32'h0010_0000, 32'h1000_0000);
        run_random_burst(150);
        set_bucket($urandom_range(0, 4095), $urandom_range(1, 1000), $urandom_range(1, 16000));
        run_random_burst(150);
    endtask

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    initial begin
        cfg_bidx  = '0;
        cfg_width = 32'd1;
        cfg_year  = 32'd1;
        cur_n     = 0;
        fut_n     = 0;
        load_window();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_directed_cases();
        test_full_under_backpressure();
        test_random_settings();

        wait_quiet();
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
